### hw/rtl/aes128_x931_random_generator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the X9.31 random generator
// Concurrent checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef AES128_X931_RANDOM_GENERATOR_DEFINES_SVH
`define AES128_X931_RANDOM_GENERATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define AX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AX_ASSERT(lbl, prop, msg)
`define AX_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### hw/rtl/ax931_pkg.sv
// ----------------------------------------------------------------------------
// ax931_pkg
// AES-128 tables and round functions shared by the generator.
// ----------------------------------------------------------------------------
package ax931_pkg;

  localparam int unsigned ROUNDS = 10;

  localparam logic [2:0] REG_KEY_HIGH      = 3'd0;
  localparam logic [2:0] REG_KEY_LOW       = 3'd1;
  localparam logic [2:0] REG_SEED_HIGH     = 3'd2;
  localparam logic [2:0] REG_SEED_LOW      = 3'd3;
  localparam logic [2:0] REG_DT_START_HIGH = 3'd4;
  localparam logic [2:0] REG_DT_START_LOW  = 3'd5;

  localparam logic [63:0] KEY_HIGH_RST  = 64'h3031323334353637;
  localparam logic [63:0] KEY_LOW_RST   = 64'h3839616263646566;
  localparam logic [63:0] SEED_HIGH_RST = 64'h7A61796278637764;
  localparam logic [63:0] SEED_LOW_RST  = 64'h7665756674677368;

  localparam logic [7:0] GF_POLY = 8'h1B;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    r = 8'h01;
    case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    rcon = r;
  endfunction

  // Byte b sits at column b/4, row b%4; byte 0 is the top byte.
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (c * 4 + r) -: 8] = SBOX[s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t col_mix(input block_t t);
    block_t s;
    logic [7:0] a0, a1, a2, a3;
    s = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = t[127 - 32 * c -: 8];
      a1 = t[119 - 32 * c -: 8];
      a2 = t[111 - 32 * c -: 8];
      a3 = t[103 - 32 * c -: 8];
      s[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      s[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      s[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      s[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    col_mix = s;
  endfunction

  // One step of the key schedule: round key n-1 to round key n.
  function automatic block_t key_step(input block_t k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[k[23:16]], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]} ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

endpackage

### hw/rtl/ax931_aes_core.sv
// ----------------------------------------------------------------------------
// ax931_aes_core
// Iterative AES-128 encryptor: one round a cycle, key schedule on the fly.
// ----------------------------------------------------------------------------
module ax931_aes_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ax931_pkg::block_t     block_in,
  input  ax931_pkg::block_t     key,
  output logic                  done,
  output ax931_pkg::block_t     block_out
);
  import ax931_pkg::*;

  block_t     s_r, rk_r;
  block_t     s_nxt, rk_nxt, sb;
  logic [3:0] rnd_r;
  logic       busy_r, done_r;

  always_comb begin
    rk_nxt = key_step(rk_r, rcon(rnd_r));
    sb     = sub_shift(s_r);
    s_nxt  = ((rnd_r == 4'(ROUNDS)) ? sb : col_mix(sb)) ^ rk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 4'd1;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 4'd1;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 4'd1;
        if (rnd_r == 4'(ROUNDS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r  <= block_in ^ key;
      rk_r <= key;
    end else if (busy_r) begin
      s_r  <= s_nxt;
      rk_r <= rk_nxt;
    end
  end

  assign done      = done_r;
  assign block_out = s_r;

endmodule

### hw/rtl/aes128_x931_random_generator.sv
// ----------------------------------------------------------------------------
// aes128_x931_random_generator
// X9.31-style random block generator around one iterative AES-128 core.
// ----------------------------------------------------------------------------
// Usage: a request word on in_* gives a byte count (0..1024, larger counts
// saturate at MAX_BLOCKS*16). The block answers with one 16-byte word per
// block on out_*, each carrying the number of leading bytes that belong to
// the request and a last flag on the final one. A zero count gives nothing.
// Per block: I = E(DT), R = E(I ^ V), V = E(R ^ I), then DT counts up.
// If R matches the previous R a single fail word (repeat_fail, last, data
// zero) ends the request and nothing is updated for that block.
// Timing: the AES core runs one round a cycle; each block takes three
// encryptions in turn (I, R, V) and then a stay in the output state, and
// the next block starts only once that word is taken. All three
// encryptions share the one AES core.
// cfg_ready is high only while idle; in_ready only while idle with no register
// write offered. A stalled receiver holds the block in the output state.
// Reset (synchronous, active low) loads key, seed and DT start registers
// with their defaults and clears the previous-block register.
// Config: cfg_index 0..5 selects key, seed and DT start halves.
// ----------------------------------------------------------------------------
`include "aes128_x931_random_generator_defines.svh"

module aes128_x931_random_generator #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] in_bytes_wanted,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data_high,
  output logic [63:0] out_data_low,
  output logic [4:0]  out_valid_bytes,
  output logic        out_repeat_fail,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ax931_pkg::*;

  localparam logic [10:0] MAX_BYTES = 11'(MAX_BLOCKS * 16);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENC_I = 3'd1;
  localparam logic [2:0] S_ENC_R = 3'd2;
  localparam logic [2:0] S_ENC_V = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state_r;
  logic        start_r;
  logic [10:0] rem_r;
  block_t      key_r, v_r, dt_r, prev_r, i_r, data_r;
  logic [4:0]  vbytes_r;
  logic        fail_r, last_r;

  block_t      aes_in, aes_out;
  logic        aes_done;
  logic [4:0]  take;
  logic [10:0] rem_after;

  ax931_aes_core u_aes (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .block_in  (aes_in),
    .key       (key_r),
    .done      (aes_done),
    .block_out (aes_out)
  );

  always_comb begin
    unique case (state_r)
      S_ENC_R: aes_in = i_r ^ v_r;
      S_ENC_V: aes_in = data_r ^ i_r;
      default: aes_in = dt_r;
    endcase
  end

  assign take      = (rem_r > 11'd16) ? 5'd16 : rem_r[4:0];
  assign rem_after = rem_r - {6'd0, take};

  // a register write has priority, so the request word waits
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      start_r  <= 1'b0;
      rem_r    <= '0;
      key_r    <= {KEY_HIGH_RST, KEY_LOW_RST};
      v_r      <= {SEED_HIGH_RST, SEED_LOW_RST};
      dt_r     <= '0;
      prev_r   <= '0;
      fail_r   <= 1'b0;
      last_r   <= 1'b0;
      vbytes_r <= '0;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_KEY_HIGH:      key_r[127:64] <= cfg_data;
              REG_KEY_LOW:       key_r[63:0]   <= cfg_data;
              REG_SEED_HIGH:     v_r[127:64]   <= cfg_data;
              REG_SEED_LOW:      v_r[63:0]     <= cfg_data;
              REG_DT_START_HIGH: dt_r[127:64]  <= cfg_data;
              REG_DT_START_LOW:  dt_r[63:0]    <= cfg_data;
              default: ;
            endcase
          end else if (in_valid && in_bytes_wanted != 11'd0) begin
            rem_r   <= (in_bytes_wanted > MAX_BYTES) ? MAX_BYTES : in_bytes_wanted;
            start_r <= 1'b1;
            state_r <= S_ENC_I;
          end
        end
        S_ENC_I: begin
          if (aes_done) begin
            start_r <= 1'b1;
            state_r <= S_ENC_R;
          end
        end
        S_ENC_R: begin
          if (aes_done) begin
            if (aes_out == prev_r) begin
              // repeated block: one fail word, nothing updated
              fail_r   <= 1'b1;
              last_r   <= 1'b1;
              vbytes_r <= '0;
              state_r  <= S_OUT;
            end else begin
              prev_r  <= aes_out;
              start_r <= 1'b1;
              state_r <= S_ENC_V;
            end
          end
        end
        S_ENC_V: begin
          if (aes_done) begin
            v_r      <= aes_out;
            dt_r     <= dt_r + 128'd1;
            fail_r   <= 1'b0;
            vbytes_r <= take;
            last_r   <= (rem_after == 11'd0);
            rem_r    <= rem_after;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (last_r) begin
              state_r <= S_IDLE;
            end else begin
              start_r <= 1'b1;
              state_r <= S_ENC_I;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_ENC_I && aes_done) begin
      i_r <= aes_out;
    end
    if (state_r == S_ENC_R && aes_done) begin
      data_r <= (aes_out == prev_r) ? '0 : aes_out;
    end
  end

  assign out_data_high   = data_r[127:64];
  assign out_data_low    = data_r[63:0];
  assign out_valid_bytes = vbytes_r;
  assign out_repeat_fail = fail_r;
  assign out_last        = last_r;

  `AX_ASSERT(a_out_blocks_in, out_valid |-> !in_ready, "input taken while a word is pending")
  `AX_ASSERT(a_fail_shape, out_valid && out_repeat_fail |-> out_last && out_valid_bytes == 5'd0,
             "fail word without last or with bytes")
  `AX_ASSERT(a_done_in_enc,
             aes_done |-> (state_r == S_ENC_I || state_r == S_ENC_R || state_r == S_ENC_V),
             "AES core finished outside an encryption phase")
  `AX_ASSERT(a_bytes_range, out_valid |-> out_valid_bytes <= 5'd16, "byte count above 16")

endmodule

### tb/sv/aes128_x931_random_generator_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the X9.31-style AES-128 random generator
// Drives byte requests and register writes, predicts every 16-byte output
// word with a behavioural AES-128/X9.31 model and checks the words in order.
// ----------------------------------------------------------------------------
module aes128_x931_random_generator_tb;
  import ax931_pkg::*;

  localparam int  MAX_BLK    = 64;
  localparam int  CYCLE_CAP  = 3000000;
  localparam int  SETTLE_CYC = 120;     // a zero request still passes through the block
  localparam int  HOLD_CYC   = 800;     // long receiver hold-off

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    logic        fail;
    logic        last;
  } rand_word_t;

  localparam logic [7:0] SUBST [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                       8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [10:0] in_bytes_wanted;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_data_high;
  logic [63:0] out_data_low;
  logic [4:0]  out_valid_bytes;
  logic        out_repeat_fail;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  aes128_x931_random_generator #(.MAX_BLOCKS(MAX_BLK)) dut (.*);

  // Predictor state: our own copy of key schedule, V, DT and last R
  logic [127:0] key_mdl, v_mdl, dt_mdl, prev_r_mdl;
  logic [31:0]  sched [44];

  logic [10:0]  request_q [$];     // requests waiting for the driver
  rand_word_t   expected_words [$];

  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;
  bit  in_taken;
  int  n_queued, n_accepted, n_words, n_fails, n_mism, n_cycles;

  initial begin
    clk = 1'b0;
  end
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioural AES-128 and X9.31 step
  // --------------------------------------------------------------------------
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    for (int k = 0; k < 4; k++) sched[k] = key_mdl[127 - 32 * k -: 32];
    for (int k = 4; k < 44; k++) begin
      t = sched[k - 1];
      if (k % 4 == 0) begin
        t = {SUBST[t[23:16]], SUBST[t[15:8]], SUBST[t[7:0]], SUBST[t[31:24]]}
            ^ {RCON[k / 4 - 1], 24'h0};
      end
      sched[k] = sched[k - 4] ^ t;
    end
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] ct;
    for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ sched[i / 4][31 - 8 * (i % 4) -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // byte sub plus row shift: byte b lives at column b/4, row b%4
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[c * 4 + r] = SUBST[s[((c + r) % 4) * 4 + r]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
        if (rnd < 10) begin
          s[c * 4]     = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
          s[c * 4 + 1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
          s[c * 4 + 2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
          s[c * 4 + 3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
        end else begin
          s[c * 4] = a0; s[c * 4 + 1] = a1; s[c * 4 + 2] = a2; s[c * 4 + 3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= sched[rnd * 4 + i / 4][31 - 8 * (i % 4) -: 8];
    end
    for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = s[i];
    return ct;
  endfunction

  // Works out every word a request produces and advances V, DT and last R
  function automatic void predict_request(input logic [10:0] wanted);
    int want, done, take;
    logic [127:0] i_blk, r_blk;
    rand_word_t w;
    want = (wanted > MAX_BLK * 16) ? MAX_BLK * 16 : int'(wanted);
    done = 0;
    while (done < want) begin
      i_blk = aes_encrypt(dt_mdl);
      r_blk = aes_encrypt(i_blk ^ v_mdl);
      if (r_blk == prev_r_mdl) begin
        // repeated block: one fail word closes the request, nothing advances
        w = '{hi: '0, lo: '0, nbytes: '0, fail: 1'b1, last: 1'b1};
        expected_words.push_back(w);
        return;
      end
      prev_r_mdl = r_blk;
      v_mdl = aes_encrypt(r_blk ^ i_blk);
      take = (want - done > 16) ? 16 : want - done;
      done += take;
      w = '{hi: r_blk[127:64], lo: r_blk[63:0], nbytes: 5'(take), fail: 1'b0,
            last: (done >= want)};
      expected_words.push_back(w);
      dt_mdl = dt_mdl + 128'd1;   // wraps from all ones to zero
    end
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] d);
    case (idx)
      REG_KEY_HIGH: begin
        key_mdl[127:64] = d;
        expand_schedule();
      end
      REG_KEY_LOW: begin
        key_mdl[63:0] = d;
        expand_schedule();
      end
      REG_SEED_HIGH:     v_mdl[127:64]  = d;
      REG_SEED_LOW:      v_mdl[63:0]    = d;
      REG_DT_START_HIGH: dt_mdl[127:64] = d;
      REG_DT_START_LOW:  dt_mdl[63:0]   = d;
      default: ;   // unmapped index, ignored
    endcase
  endfunction

  // Request sizes: mostly short, a few full-size and over-size ones
  function automatic logic [10:0] pick_request();
    int sel;
    sel = $urandom_range(99);
    if (sel < 6) return 11'd0;
    if (sel < 68) return 11'($urandom_range(64, 1));
    if (sel < 92) return 11'($urandom_range(400, 65));
    if (sel < 96) return 11'($urandom_range(1024, 1000));
    return 11'($urandom_range(2047, 1025));
  endfunction

  // --------------------------------------------------------------------------
  // Driver and receiver back-pressure, all changes on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid        <= 1'b1;
        in_bytes_wanted <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Rising edge: track accepted requests and register writes, check words
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rand_word_t exp_w;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        predict_request(in_bytes_wanted);
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        n_words++;
        if (out_repeat_fail) n_fails++;
        if (expected_words.size() == 0) begin
          n_mism++;
          if (n_mism <= 10) $display("unexpected word: data %h_%h bytes %0d fail %0b last %0b",
                                     out_data_high, out_data_low, out_valid_bytes,
                                     out_repeat_fail, out_last);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data_high !== exp_w.hi || out_data_low !== exp_w.lo ||
              out_valid_bytes !== exp_w.nbytes || out_repeat_fail !== exp_w.fail ||
              out_last !== exp_w.last) begin
            n_mism++;
            if (n_mism <= 10) begin
              $display("word %0d mismatch: exp %h_%h b%0d f%0b l%0b", n_words,
                       exp_w.hi, exp_w.lo, exp_w.nbytes, exp_w.fail, exp_w.last);
              $display("                  got %h_%h b%0d f%0b l%0b",
                       out_data_high, out_data_low, out_valid_bytes, out_repeat_fail, out_last);
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d words outstanding", n_cycles,
               expected_words.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Long receiver hold-off during the first random phase; sender keeps going
  initial begin
    hold_off = 1'b0;
    wait (n_queued > 40);
    hold_off = 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_off = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  task automatic queue_request(input logic [10:0] nb);
    request_q.push_back(nb);
    n_queued++;
  endtask

  // Block is idle once every request is taken and every word has come back
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_state(input logic [127:0] v, input logic [127:0] dt);
    write_reg(REG_SEED_HIGH, v[127:64]);
    write_reg(REG_SEED_LOW, v[63:0]);
    write_reg(REG_DT_START_HIGH, dt[127:64]);
    write_reg(REG_DT_START_LOW, dt[63:0]);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_bytes_wanted = '0; out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_taken = 1'b0;
    n_queued = 0; n_accepted = 0; n_words = 0; n_fails = 0; n_mism = 0; n_cycles = 0;
    send_idle_pct = 18; recv_idle_pct = 59;
    key_mdl = {KEY_HIGH_RST, KEY_LOW_RST};
    v_mdl = {SEED_HIGH_RST, SEED_LOW_RST};
    dt_mdl = '0;
    prev_r_mdl = '0;
    expand_schedule();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: sizes around word boundaries, zero, full and saturated requests
    queue_request(11'd0);    queue_request(11'd1);    queue_request(11'd15);
    queue_request(11'd16);   queue_request(11'd17);   queue_request(11'd33);
    queue_request(11'd0);    queue_request(11'd1024); queue_request(11'd1025);
    queue_request(11'd2047); queue_request(11'd5);
    wait_drained();

    // Repeat detection: load the same V and DT twice, so R recurs
    load_state(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210, 128'd5);
    queue_request(11'd16);
    wait_drained();
    load_state(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210, 128'd5);
    queue_request(11'd40);
    wait_drained();

    // Extremes: all-ones key, zero seed, DT just below wrap; stray indexes
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    load_state('0, {128{1'b1}} - 128'd1);
    write_reg(3'd6, 64'h0123_4567_89ab_cdef);
    write_reg(3'd7, '1);
    queue_request(11'd48);
    queue_request(11'd1);
    wait_drained();
    write_reg(REG_KEY_HIGH, '0);
    write_reg(REG_KEY_LOW, '0);
    load_state({128{1'b1}}, {64'h0, 64'hffff_ffff_ffff_ffff});
    queue_request(11'd32);
    wait_drained();

    // Random phase 1: light sender gaps, heavy receiver stalls plus hold-off
    for (int i = 0; i < 75; i++) queue_request(pick_request());
    wait_drained();

    write_reg(REG_KEY_HIGH, {$urandom, $urandom});
    write_reg(REG_KEY_LOW, {$urandom, $urandom});
    load_state({$urandom, $urandom, $urandom, $urandom}, {$urandom, $urandom, 64'h0});
    send_idle_pct = 59; recv_idle_pct = 18;
    for (int i = 0; i < 75; i++) queue_request(pick_request());
    wait_drained();

    write_reg(REG_KEY_LOW, {$urandom, $urandom});
    load_state({$urandom, $urandom, $urandom, $urandom},
               {$urandom, $urandom, $urandom, $urandom});
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 70; i++) queue_request(pick_request());
    wait_drained();

    repeat (200) @(negedge clk);
    $display("covered %0d requests, %0d words (%0d repeat fails) in %0d cycles",
             n_accepted, n_words, n_fails, n_cycles);
    $display("register rewrites at extremes, DT wrap, saturated sizes, %0d mismatches",
             n_mism);
    if (n_mism == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
